// ----- hdl/abmd_pkg.sv -----
// Shared types, constants and lookup tables for the archive block decrypt unit.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package abmd_pkg;

    // Number of leading blocks of a file that are always decoded.
    localparam int HEADER_BLOCKS = 20;
    localparam int HEAD_CNT_W    = 5;
    localparam int PHASE_W       = 6;
    localparam int SHUF_CNT_W    = 3;

    // Work queue between classifier and datapath.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;
    localparam int DIGIT_W    = 5;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_ONLY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ACT_PASS    = 2'd0,
        ACT_DECODE  = 2'd1,
        ACT_SHUFFLE = 2'd2
    } t_action;

    typedef struct packed {
        logic [63:0] block_in;
        logic        last_block;
    } t_item;

    typedef struct packed {
        logic [63:0] block_out;
        logic [1:0]  action;
    } t_result;

    // One queued job: raw block plus the operation picked for it.
    typedef struct packed {
        logic [63:0] blk;
        t_action     act;
    } t_work;

    // Permutation tables, 1-based bit positions, position 1 = MSB.
    localparam logic [6:0] IP_TAB [64] = '{
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
    };

    localparam logic [6:0] FP_TAB [64] = '{
        7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
        7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
        7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
        7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
        7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
        7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
        7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
        7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
    };

    localparam logic [5:0] P_TAB [32] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    // Packed S tables: high nibble used by the even lookup, low by the odd.
    localparam logic [7:0] SBOX [4][64] = '{
        '{8'hef,8'h03,8'h41,8'hfd,8'hd8,8'h74,8'h1e,8'h47,
          8'h26,8'hef,8'hfb,8'h22,8'hb3,8'hd8,8'h84,8'h1e,
          8'h39,8'hac,8'ha7,8'h60,8'h62,8'hc1,8'hcd,8'hba,
          8'h5c,8'h96,8'h90,8'h59,8'h05,8'h3b,8'h7a,8'h85,
          8'h40,8'hfd,8'h1e,8'hc8,8'he7,8'h8a,8'h8b,8'h21,
          8'hda,8'h43,8'h64,8'h9f,8'h2d,8'h14,8'hb1,8'h72,
          8'hf5,8'h5b,8'hc8,8'hb6,8'h9c,8'h37,8'h76,8'hec,
          8'h39,8'ha0,8'ha3,8'h05,8'h52,8'h6e,8'h0f,8'hd9},
        '{8'ha7,8'hdd,8'h0d,8'h78,8'h9e,8'h0b,8'he3,8'h95,
          8'h60,8'h36,8'h36,8'h4f,8'hf9,8'h60,8'h5a,8'ha3,
          8'h11,8'h24,8'hd2,8'h87,8'hc8,8'h52,8'h75,8'hec,
          8'hbb,8'hc1,8'h4c,8'hba,8'h24,8'hfe,8'h8f,8'h19,
          8'hda,8'h13,8'h66,8'haf,8'h49,8'hd0,8'h90,8'h06,
          8'h8c,8'h6a,8'hfb,8'h91,8'h37,8'h8d,8'h0d,8'h78,
          8'hbf,8'h49,8'h11,8'hf4,8'h23,8'he5,8'hce,8'h3b,
          8'h55,8'hbc,8'ha2,8'h57,8'he8,8'h22,8'h74,8'hce},
        '{8'h2c,8'hea,8'hc1,8'hbf,8'h4a,8'h24,8'h1f,8'hc2,
          8'h79,8'h47,8'ha2,8'h7c,8'hb6,8'hd9,8'h68,8'h15,
          8'h80,8'h56,8'h5d,8'h01,8'h33,8'hfd,8'hf4,8'hae,
          8'hde,8'h30,8'h07,8'h9b,8'he5,8'h83,8'h9b,8'h68,
          8'h49,8'hb4,8'h2e,8'h83,8'h1f,8'hc2,8'hb5,8'h7c,
          8'ha2,8'h19,8'hd8,8'he5,8'h7c,8'h2f,8'h83,8'hda,
          8'hf7,8'h6b,8'h90,8'hfe,8'hc4,8'h01,8'h5a,8'h97,
          8'h61,8'ha6,8'h3d,8'h40,8'h0b,8'h58,8'he6,8'h3d},
        '{8'h4d,8'hd1,8'hb2,8'h0f,8'h28,8'hbd,8'he4,8'h78,
          8'hf6,8'h4a,8'h0f,8'h93,8'h8b,8'h17,8'hd1,8'ha4,
          8'h3a,8'hec,8'hc9,8'h35,8'h93,8'h56,8'h7e,8'hcb,
          8'h55,8'h20,8'ha0,8'hfe,8'h6c,8'h89,8'h17,8'h62,
          8'h17,8'h62,8'h4b,8'hb1,8'hb4,8'hde,8'hd1,8'h87,
          8'hc9,8'h14,8'h3c,8'h4a,8'h7e,8'ha8,8'he2,8'h7d,
          8'ha0,8'h9f,8'hf6,8'h5c,8'h6a,8'h09,8'h8d,8'hf0,
          8'h0f,8'he3,8'h53,8'h25,8'h95,8'h36,8'h28,8'hcb}
    };

    // Byte 7 substitution of the shuffle: fixed pairwise swaps.
    function automatic logic [7:0] swap_byte(input logic [7:0] v);
        logic [7:0] r;
        unique case (v)
            8'h00: r = 8'h2b;
            8'h2b: r = 8'h00;
            8'h01: r = 8'h68;
            8'h68: r = 8'h01;
            8'h48: r = 8'h77;
            8'h77: r = 8'h48;
            8'h60: r = 8'hff;
            8'hff: r = 8'h60;
            8'h6c: r = 8'h80;
            8'h80: r = 8'h6c;
            8'hb9: r = 8'hc0;
            8'hc0: r = 8'hb9;
            8'heb: r = 8'hfe;
            8'hfe: r = 8'heb;
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/abmd_front.sv -----
// Classifier: configuration registers, file counters, per-block action pick.
// Depends on abmd_pkg.
`default_nettype none

module abmd_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire abmd_pkg::t_item            i_item,
    output logic                            o_full,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [abmd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [abmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                       i_q_full,
    output logic                            o_q_push,
    output abmd_pkg::t_work                 o_q_data
);
    import abmd_pkg::*;

    logic                  r_header_only;
    logic [DIGIT_W-1:0]    r_digit_count;
    logic [HEAD_CNT_W-1:0] r_head_count, n_head_count;
    logic [PHASE_W-1:0]    r_cycle_phase, n_cycle_phase;
    logic [SHUF_CNT_W-1:0] r_shuffle_count, n_shuffle_count;

    logic [PHASE_W-1:0] cyc;
    logic [PHASE_W-1:0] phase;
    logic [PHASE_W-1:0] phase_inc;
    logic               in_head;
    logic               do_decode;
    logic               do_shuffle;
    logic               accept;
    t_action            act;

    assign o_full      = i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_push && !i_q_full;

    // Effective decode period from the digit count (3..46).
    always_comb begin
        if (r_digit_count < DIGIT_W'(3)) begin
            cyc = PHASE_W'(3);
        end else if (r_digit_count < DIGIT_W'(5)) begin
            cyc = PHASE_W'(r_digit_count) + PHASE_W'(1);
        end else if (r_digit_count < DIGIT_W'(7)) begin
            cyc = PHASE_W'(r_digit_count) + PHASE_W'(9);
        end else begin
            cyc = PHASE_W'(r_digit_count) + PHASE_W'(15);
        end
    end

    always_comb begin
        // stale phase after a period change counts as zero
        phase      = (r_cycle_phase >= cyc) ? '0 : r_cycle_phase;
        phase_inc  = phase + PHASE_W'(1);
        in_head    = r_head_count < HEAD_CNT_W'(HEADER_BLOCKS);
        do_decode  = in_head || (!r_header_only && phase == '0);
        do_shuffle = !do_decode && !r_header_only && (r_shuffle_count == '1);

        if (do_decode) begin
            act = ACT_DECODE;
        end else if (do_shuffle) begin
            act = ACT_SHUFFLE;
        end else begin
            act = ACT_PASS;
        end

        n_shuffle_count = r_shuffle_count;
        if (!do_decode) begin
            n_shuffle_count = do_shuffle ? SHUF_CNT_W'(1) : r_shuffle_count + SHUF_CNT_W'(1);
        end
        n_head_count  = in_head ? r_head_count + HEAD_CNT_W'(1) : r_head_count;
        n_cycle_phase = (phase_inc >= cyc) ? '0 : phase_inc;

        if (i_item.last_block) begin
            n_head_count    = '0;
            n_cycle_phase   = '0;
            n_shuffle_count = '0;
        end
    end

    assign o_q_push      = accept;
    assign o_q_data.blk  = i_item.block_in;
    assign o_q_data.act  = act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_only   <= 1'b0;
            r_digit_count   <= '0;
            r_head_count    <= '0;
            r_cycle_phase   <= '0;
            r_shuffle_count <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_HEADER_ONLY: r_header_only <= i_cfg_data[0];
                    REG_DIGIT_COUNT: r_digit_count <= i_cfg_data[DIGIT_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_head_count    <= n_head_count;
                r_cycle_phase   <= n_cycle_phase;
                r_shuffle_count <= n_shuffle_count;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/abmd_queue.sv -----
// Short work queue between classifier and datapath, register array storage.
// Depends on abmd_pkg.
`default_nettype none

module abmd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire abmd_pkg::t_work i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output abmd_pkg::t_work      o_data,
    output logic                 o_empty
);
    import abmd_pkg::*;

    t_work              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push;
    logic               do_pop;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/abmd_back.sv -----
// Datapath: one-round DES decode, byte shuffle or pass-through, into the result register.
// Depends on abmd_pkg (permutation tables, S tables, swap map).
`default_nettype none

module abmd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_empty,
    input  wire abmd_pkg::t_work i_q_data,
    output logic                 o_q_pop,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output abmd_pkg::t_result    o_result
);
    import abmd_pkg::*;

    logic        r_valid;
    t_result     r_result;
    logic        load;
    logic [63:0] dec_blk;
    logic [63:0] shuf_blk;
    t_result     n_result;

    function automatic logic [63:0] perm64(input logic [63:0] v, input logic is_final);
        logic [63:0] r;
        int          j;
        r = '0;
        for (int i = 0; i < 64; i++) begin
            j = 64 - int'(is_final ? FP_TAB[i] : IP_TAB[i]);
            r[63-i] = v[j];
        end
        return r;
    endfunction

    function automatic logic [63:0] des_round(input logic [63:0] v);
        logic [63:0] b;
        logic [31:0] rh;
        logic [5:0]  e [8];
        logic [31:0] s;
        logic [31:0] f;
        int          j;
        b = perm64(v, 1'b0);
        rh = b[31:0];
        // expansion of the right half
        e[0] = {rh[0],     rh[31:27]};
        e[1] = rh[28:23];
        e[2] = rh[24:19];
        e[3] = rh[20:15];
        e[4] = rh[16:11];
        e[5] = rh[12:7];
        e[6] = rh[8:3];
        e[7] = {rh[4:0],   rh[31]};
        for (int i = 0; i < 4; i++) begin
            s[31-8*i -: 8] = {SBOX[i][e[2*i]][7:4], SBOX[i][e[2*i+1]][3:0]};
        end
        f = '0;
        for (int i = 0; i < 32; i++) begin
            j = 32 - int'(P_TAB[i]);
            f[31-i] = s[j];
        end
        b[63:32] = b[63:32] ^ f;
        return perm64(b, 1'b1);
    endfunction

    assign dec_blk = des_round(i_q_data.blk);

    // output bytes 0..6 take input bytes 3,4,6,0,1,2,5; byte 7 is remapped
    assign shuf_blk = {i_q_data.blk[39:32], i_q_data.blk[31:24], i_q_data.blk[15:8],
                       i_q_data.blk[63:56], i_q_data.blk[55:48], i_q_data.blk[47:40],
                       i_q_data.blk[23:16], swap_byte(i_q_data.blk[7:0])};

    always_comb begin
        n_result.action = i_q_data.act;
        case (i_q_data.act)
            ACT_DECODE:  n_result.block_out = dec_blk;
            ACT_SHUFFLE: n_result.block_out = shuf_blk;
            default:     n_result.block_out = i_q_data.blk;
        endcase
    end

    assign load     = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop  = load;
    assign o_empty  = !r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/archive_block_mixed_decrypt_unit.sv -----
// Top level of the archive block decrypt unit: classifier, work queue, datapath.
// Depends on abmd_pkg, abmd_front, abmd_queue, abmd_back.
//
// Usage:
//   Input queue side: drive i_item and raise i_push; the block is taken at a
//   clock edge where i_push is high and o_full is low. One block per cycle.
//   Output queue side: while o_empty is low, o_result holds the oldest result;
//   raise i_pop to take it. A new result can be loaded in the same cycle.
//   Config: i_cfg_valid with i_cfg_index/i_cfg_data; o_cfg_ready is always
//   high, so every write transfer completes without waiting. Index 0 is
//   header_only, index 1 is digit_count; other indexes are ignored.
//   Path: a taken block is written into the work queue, then loaded into
//   the result register, where o_empty goes low and it can be popped.
//   Throughput: one block per cycle while results are popped; the datapath
//   does the DES round or shuffle combinationally into the result register.
//   Stalls: if i_pop stays low, the result register holds and the 4-entry
//   work queue fills; o_full then rises until the output drains.
//   Reset (synchronous, i_rst_n low): queue and result register empty,
//   counters and configuration back to zero.
`default_nettype none

module archive_block_mixed_decrypt_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    input  wire abmd_pkg::t_item                 i_item,
    output logic                                 o_full,
    output logic                                 o_empty,
    input  wire logic                            i_pop,
    output abmd_pkg::t_result                    o_result,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [abmd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [abmd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import abmd_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    t_work q_wdata;
    t_work q_rdata;

    // classify each block and advance the file counters
    abmd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    // decouples classifier from datapath stalls
    abmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // transform and hold the result until it is transferred out
    abmd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire
